// ===== design/ising_pkg.sv =====
// Shared widths, codes and control types of the Ising chain update block.
`default_nettype none

package ising_pkg;

    // Payload widths
    localparam int SITE_W = 10;
    localparam int WORD_W = 32;
    localparam int J_W    = 16;
    localparam int T_W    = 33;
    localparam int E_W    = 29;
    localparam int M_W    = 12;
    localparam int THR_N  = 6;

    // APB register port
    localparam int APB_AW = 6;
    localparam int APB_DW = 64;

    // Request operation codes
    localparam logic OP_FORCE = 1'b0;
    localparam logic OP_TRIAL = 1'b1;

    // Threshold bank bases: new spin up, new spin down
    localparam logic [2:0] THR_UP_BASE   = 3'd0;
    localparam logic [2:0] THR_DOWN_BASE = 3'd3;

    localparam logic [T_W-1:0] THR_ALWAYS = {1'b1, {(T_W-1){1'b0}}};

    typedef enum logic [2:0] {
        REG_COUPLING_J     = 3'd0,
        REG_FIELD_H        = 3'd1,
        REG_THR_UP_DOWN    = 3'd2,
        REG_THR_UP_MIXED   = 3'd3,
        REG_THR_UP_UP      = 3'd4,
        REG_THR_DOWN_DOWN  = 3'd5,
        REG_THR_DOWN_MIXED = 3'd6,
        REG_THR_DOWN_UP    = 3'd7
    } t_reg_idx;

    typedef struct packed {
        logic signed [J_W-1:0]       coupling_j;
        logic signed [J_W-1:0]       field_h;
        logic [THR_N-1:0][T_W-1:0]   thr;
    } t_cfg;

    // Controller to datapath
    typedef struct packed {
        logic clr_wr;      // write one cleared entry
        logic capture;     // take request, read site and left neighbour
        logic read_right;  // read right neighbour
        logic exec;        // decide, write back, load result
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic clr_last;
        logic out_free;
    } t_status;

endpackage

`default_nettype wire

// ===== design/ising_if.sv =====
// Request and result channel interfaces of the Ising chain update block.
`default_nettype none

interface ising_trial_if;
    import ising_pkg::*;

    logic              valid;
    logic              ready;
    logic              operation;
    logic [SITE_W-1:0] site;
    logic              spin_value;
    logic [WORD_W-1:0] uniform_word;

    modport source (output valid, operation, site, spin_value, uniform_word, input ready);
    modport sink   (input valid, operation, site, spin_value, uniform_word, output ready);
endinterface

interface ising_result_if;
    import ising_pkg::*;

    logic                 valid;
    logic                 ready;
    logic                 accepted;
    logic                 spin_after;
    logic signed [E_W-1:0] energy_total;
    logic signed [M_W-1:0] magnetization_total;

    modport source (output valid, accepted, spin_after, energy_total, magnetization_total,
                    input ready);
    modport sink   (input valid, accepted, spin_after, energy_total, magnetization_total,
                    output ready);
endinterface

`default_nettype wire

// ===== design/ising_cfg.sv =====
// APB configuration registers: coupling, field and acceptance thresholds.
`default_nettype none

module ising_cfg (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [ising_pkg::APB_AW-1:0]  paddr,
    input  wire logic [ising_pkg::APB_DW-1:0]  pwdata,
    output      logic [ising_pkg::APB_DW-1:0]  prdata,
    output      ising_pkg::t_cfg               o_cfg
);
    import ising_pkg::*;

    t_cfg     r_cfg;
    t_reg_idx w_idx;
    logic     w_wr;

    assign w_idx = t_reg_idx'(paddr[5:3]);
    assign w_wr  = psel & penable & pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.coupling_j <= J_W'(1);
            r_cfg.field_h    <= '0;
            r_cfg.thr        <= {THR_N{THR_ALWAYS}};
        end else if (w_wr) begin
            case (w_idx)
                REG_COUPLING_J:     r_cfg.coupling_j <= pwdata[J_W-1:0];
                REG_FIELD_H:        r_cfg.field_h    <= pwdata[J_W-1:0];
                REG_THR_UP_DOWN:    r_cfg.thr[0]     <= pwdata[T_W-1:0];
                REG_THR_UP_MIXED:   r_cfg.thr[1]     <= pwdata[T_W-1:0];
                REG_THR_UP_UP:      r_cfg.thr[2]     <= pwdata[T_W-1:0];
                REG_THR_DOWN_DOWN:  r_cfg.thr[3]     <= pwdata[T_W-1:0];
                REG_THR_DOWN_MIXED: r_cfg.thr[4]     <= pwdata[T_W-1:0];
                REG_THR_DOWN_UP:    r_cfg.thr[5]     <= pwdata[T_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (w_idx)
            REG_COUPLING_J:     prdata = APB_DW'(r_cfg.coupling_j);
            REG_FIELD_H:        prdata = APB_DW'(r_cfg.field_h);
            REG_THR_UP_DOWN:    prdata = APB_DW'(r_cfg.thr[0]);
            REG_THR_UP_MIXED:   prdata = APB_DW'(r_cfg.thr[1]);
            REG_THR_UP_UP:      prdata = APB_DW'(r_cfg.thr[2]);
            REG_THR_DOWN_DOWN:  prdata = APB_DW'(r_cfg.thr[3]);
            REG_THR_DOWN_MIXED: prdata = APB_DW'(r_cfg.thr[4]);
            REG_THR_DOWN_UP:    prdata = APB_DW'(r_cfg.thr[5]);
            default:            prdata = '0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

// ===== design/ising_ctrl.sv =====
// Sequencer: clearing pass, request capture, neighbour read and execute.
`default_nettype none

module ising_ctrl (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output      logic               o_in_ready,
    input  wire ising_pkg::t_status i_status,
    output      ising_pkg::t_cmd    o_cmd
);
    import ising_pkg::*;

    typedef enum logic [3:0] {
        S_CLEAR = 4'b0001,
        S_IDLE  = 4'b0010,
        S_READ  = 4'b0100,
        S_EXEC  = 4'b1000
    } t_state;

    t_state r_state, n_state;

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_CLEAR: begin
                o_cmd.clr_wr = 1'b1;
                if (i_status.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_READ;
                end
            end
            S_READ: begin
                o_cmd.read_right = 1'b1;
                n_state          = S_EXEC;
            end
            S_EXEC: begin
                // hold until the result register has room
                if (i_status.out_free) begin
                    o_cmd.exec = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

`default_nettype wire

// ===== design/ising_dpath.sv =====
// Spin memory, energy and magnetization sums, acceptance decision, result register.
`default_nettype none

module ising_dpath #(
    parameter int LENGTH = 1024
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire ising_pkg::t_cmd                  i_cmd,
    output      ising_pkg::t_status               o_status,
    input  wire ising_pkg::t_cfg                  i_cfg,
    input  wire logic                             i_operation,
    input  wire logic [ising_pkg::SITE_W-1:0]     i_site,
    input  wire logic                             i_spin_value,
    input  wire logic [ising_pkg::WORD_W-1:0]     i_uniform_word,
    input  wire logic                             i_out_ready,
    output      logic                             o_out_valid,
    output      logic                             o_accepted,
    output      logic                             o_spin_after,
    output      logic signed [ising_pkg::E_W-1:0] o_energy_total,
    output      logic signed [ising_pkg::M_W-1:0] o_magnetization_total
);
    import ising_pkg::*;

    localparam int AW = (LENGTH > 2) ? $clog2(LENGTH) : 1;
    localparam int CW = ((AW > SITE_W) ? AW : SITE_W) + 1;
    localparam logic [AW-1:0]  LAST_A  = AW'(LENGTH - 1);
    localparam logic [M_W-1:0] MAG_RST = M_W'(LENGTH);
    localparam logic [M_W-1:0] MAG_STEP = M_W'(2);

    logic r_spin_mem [LENGTH];

    // request registers
    logic              r_op;
    logic              r_val;
    logic [WORD_W-1:0] r_word;
    logic              r_in_range;
    logic [AW-1:0]     r_site_a;
    logic [AW-1:0]     r_right_a;
    logic              r_q0;     // site spin, then right neighbour
    logic              r_q1;     // left neighbour
    logic              r_old;

    logic [AW-1:0]          r_clr_addr;
    logic signed [E_W-1:0]  r_energy;
    logic signed [M_W-1:0]  r_mag;
    logic                   r_out_valid;
    logic                   r_out_acc;
    logic                   r_out_spin;

    logic [CW-1:0] w_site_ext;
    logic [AW-1:0] w_site_a, w_left_a, w_right_a, w_rd0_a;
    logic          w_wr_en, w_wr_data;
    logic [AW-1:0] w_wr_a;

    logic                w_s_new;
    logic [1:0]          w_ups;
    logic [2:0]          w_sel;
    logic [T_W-1:0]      w_thr;
    logic                w_pass;
    logic                w_apply;
    logic                w_acc;
    logic signed [18:0]  w_j2, w_h, w_jnb, w_t;
    logic signed [19:0]  w_de2, w_de;

    // ring addresses of the incoming request
    assign w_site_ext = CW'(i_site);
    assign w_site_a   = w_site_ext[AW-1:0];
    assign w_left_a   = (w_site_a == '0) ? LAST_A : w_site_a - AW'(1);
    assign w_right_a  = (w_site_a == LAST_A) ? '0 : w_site_a + AW'(1);
    assign w_rd0_a    = i_cmd.capture ? w_site_a : r_right_a;

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_op       <= i_operation;
            r_val      <= i_spin_value;
            r_word     <= i_uniform_word;
            r_in_range <= w_site_ext < CW'(LENGTH);
            r_site_a   <= w_site_a;
            r_right_a  <= w_right_a;
        end
        if (i_cmd.read_right) begin
            r_old <= r_q0;
        end
    end

    // spin memory: two registered read ports, one write port
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture || i_cmd.read_right) begin
            r_q0 <= r_spin_mem[w_rd0_a];
        end
        if (i_cmd.capture) begin
            r_q1 <= r_spin_mem[w_left_a];
        end
        if (w_wr_en) begin
            r_spin_mem[w_wr_a] <= w_wr_data;
        end
    end

    // decision
    assign w_s_new = (r_op == OP_TRIAL) ? ~r_old : r_val;
    assign w_ups   = {1'b0, r_q1} + {1'b0, r_q0};
    assign w_sel   = (w_s_new ? THR_UP_BASE : THR_DOWN_BASE) + 3'(w_ups);
    assign w_thr   = i_cfg.thr[w_sel];
    assign w_pass  = {1'b0, r_word} < w_thr;

    assign w_j2 = 19'(i_cfg.coupling_j) <<< 1;
    assign w_h  = 19'(i_cfg.field_h);

    always_comb begin
        case (w_ups)
            2'd0:    w_jnb = -w_j2;
            2'd2:    w_jnb = w_j2;
            default: w_jnb = '0;
        endcase
    end

    // dE = -2 * s' * (J * (left + right) + h)
    assign w_t   = w_jnb + w_h;
    assign w_de2 = 20'(w_t) <<< 1;
    assign w_de  = w_s_new ? -w_de2 : w_de2;

    assign w_acc   = r_in_range & ((r_op == OP_TRIAL) ? w_pass : 1'b1);
    assign w_apply = r_in_range & ((r_op == OP_TRIAL) ? w_pass : (r_val != r_old));

    assign w_wr_en   = i_cmd.clr_wr | (i_cmd.exec & w_apply);
    assign w_wr_a    = i_cmd.clr_wr ? r_clr_addr : r_site_a;
    assign w_wr_data = i_cmd.clr_wr | w_s_new;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr  <= '0;
            r_energy    <= '0;
            r_mag       <= MAG_RST;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.clr_wr) begin
                r_clr_addr <= r_clr_addr + AW'(1);
            end
            if (i_cmd.exec && w_apply) begin
                r_energy <= r_energy + E_W'(w_de);
                r_mag    <= w_s_new ? r_mag + MAG_STEP : r_mag - MAG_STEP;
            end
            if (i_cmd.exec) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            r_out_acc  <= w_acc;
            r_out_spin <= r_in_range & (w_apply ? w_s_new : r_old);
        end
    end

    assign o_status.clr_last = (r_clr_addr == LAST_A);
    assign o_status.out_free = ~r_out_valid | i_out_ready;

    // the sums only move on execute, which waits for the result to leave
    assign o_out_valid           = r_out_valid;
    assign o_accepted            = r_out_acc;
    assign o_spin_after          = r_out_spin;
    assign o_energy_total        = r_energy;
    assign o_magnetization_total = r_mag;

endmodule

`default_nettype wire

// ===== design/ising_chain_metropolis_step.sv =====
// Top level of the periodic Ising chain Metropolis update block.
//
//  Channel   Direction  Handshake          Carries
//  i_trial   in         valid/ready        operation, site, spin_value, uniform_word
//  o_result  out        valid/ready        accepted, spin_after, energy_total,
//                                          magnetization_total
//  APB       in/out     psel/penable       coupling, field, six thresholds (8*i)
//
// Each request passes through capture, read and execute: capture reads the site
// and its left neighbour, read fetches the right neighbour, and execute decides,
// writes the spin back and loads the result. The spin memory has two read ports,
// so the right neighbour needs its own read step. After reset a clearing pass sets
// all LENGTH spins up, one per cycle, and no request is accepted meanwhile.
// A result waits in the output register while the next request is taken;
// its execute step holds until that result leaves.
`default_nettype none

module ising_chain_metropolis_step #(
    parameter int LENGTH = 1024
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    ising_trial_if.sink                        i_trial,
    ising_result_if.source                     o_result,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [ising_pkg::APB_AW-1:0]  paddr,
    input  wire logic [ising_pkg::APB_DW-1:0]  pwdata,
    output      logic [ising_pkg::APB_DW-1:0]  prdata,
    output      logic                          pready
);
    import ising_pkg::*;

    t_cfg    w_cfg;
    t_cmd    w_cmd;
    t_status w_status;

    // register writes complete in the access phase without wait states
    assign pready = 1'b1;

    ising_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .o_cfg   (w_cfg)
    );

    // sequencer: owns request acceptance
    ising_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_trial.valid),
        .o_in_ready (i_trial.ready),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    // datapath: spin memory, sums and result register
    ising_dpath #(
        .LENGTH (LENGTH)
    ) u_dpath (
        .i_clk                 (i_clk),
        .i_rst_n               (i_rst_n),
        .i_cmd                 (w_cmd),
        .o_status              (w_status),
        .i_cfg                 (w_cfg),
        .i_operation           (i_trial.operation),
        .i_site                (i_trial.site),
        .i_spin_value          (i_trial.spin_value),
        .i_uniform_word        (i_trial.uniform_word),
        .i_out_ready           (o_result.ready),
        .o_out_valid           (o_result.valid),
        .o_accepted            (o_result.accepted),
        .o_spin_after          (o_result.spin_after),
        .o_energy_total        (o_result.energy_total),
        .o_magnetization_total (o_result.magnetization_total)
    );

    // execute always leaves a result behind
    a_exec_loads_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.exec |=> o_result.valid)
        else $error("execute did not load a result");

    // no request taken while the spin memory is being cleared
    a_no_accept_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.clr_wr |-> !i_trial.ready)
        else $error("request accepted during clearing pass");

    // execute never overwrites a result still waiting
    a_exec_has_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.exec |-> (!o_result.valid || o_result.ready))
        else $error("execute overwrote a pending result");

    // energy moves only on execute
    a_energy_only_on_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_cmd.exec |=> $stable(o_result.energy_total))
        else $error("energy changed outside execute");

endmodule

`default_nettype wire
